// ----- sv/lrukv_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types and constants for the LRU key-value cache unit: request and
// response payloads, controller command and status bundles, request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

    // Request kinds.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Value returned by a get that misses.
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    // Capacity register width and reset value.
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // One request transaction.
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } lrukv_req_t;

    // One response transaction.
    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
    } lrukv_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // take the request in, clear the scan trackers
        logic sweep_clear;  // restart the entry sweep counter
        logic sweep_run;    // step the entry sweep
        logic scan_mode;    // sweep compares keys (else it ages ranks)
        logic decide;       // pick the target slot and update storage
        logic latch;        // capture the value read for a get hit
        logic final_wr;     // write rank zero to the target slot
        logic load_out;     // load the response register
    } lrukv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic promote_needed;
    } lrukv_stat_t;

endpackage

`default_nettype wire

// ----- sv/lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache unit
// Fully associative key-value store with least recently used replacement.
//
//   Channel   Ports                        Direction  Payload
//   request   s_valid s_ready s_data       in         cmd, key, value
//   response  m_valid m_ready m_data       out        found, read_value
//   config    cfg_wr_en cfg_wr_data        in         active_capacity
//
// A request runs through the key scan, the decision and the value latch, then,
// when an entry is promoted, the rank aging sweep and the final rank write, to
// a loaded response. The key scan and the rank aging sweep each step one entry
// per cycle through the single read port of the key and rank memories. The next
// request is taken in the cycle after the response is loaded.
// Reset is synchronous, clears the valid bits and occupancy and sets the
// capacity to 16.
// A stalled response stays in its register while the next request is taken
// and scanned; that request waits before loading its own response.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire lrukv_pkg::lrukv_req_t       s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output lrukv_pkg::lrukv_rsp_t            m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data
);

    import lrukv_pkg::*;

    lrukv_cmd_t  cmd;
    lrukv_stat_t stat;

    // Request sequencing.
    lrukv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Storage, scan and response datapath.
    lrukv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .req_in      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_out     (m_data)
    );

endmodule

`default_nettype wire

// ----- sv/lrukv_ram.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache RAM
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on the storage.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/lrukv_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences one request: key scan, decision, rank aging sweep, final rank
// write and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lrukv_pkg::lrukv_cmd_t      cmd,
    input  wire lrukv_pkg::lrukv_stat_t stat
);

    import lrukv_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DECIDE  = 3'd2;
    localparam logic [2:0] ST_LATCH   = 3'd3;
    localparam logic [2:0] ST_PROMOTE = 3'd4;
    localparam logic [2:0] ST_FINAL   = 3'd5;
    localparam logic [2:0] ST_RESP    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture     = 1'b1;
                    cmd.sweep_clear = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.sweep_run = 1'b1;
                cmd.scan_mode = 1'b1;
                if (stat.sweep_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                cmd.latch       = 1'b1;
                cmd.sweep_clear = 1'b1;
                state_next      = stat.promote_needed ? ST_PROMOTE : ST_RESP;
            end
            ST_PROMOTE: begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.final_wr = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The response register stays full until the downstream side takes it.
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    // A new response never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("response register overwritten");

    // An accepted request always starts a key scan.
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

    // Aging only follows a decision that asked for it.
    a_promote_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LATCH && !stat.promote_needed) |=> (state_reg == ST_RESP))
        else $error("rank sweep without a promotion");

endmodule

`default_nettype wire

// ----- sv/lrukv_datapath.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key, value and rank memories, valid bits, occupancy, the entry sweep with
// its hit, oldest and free-slot trackers, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lrukv_pkg::lrukv_cmd_t       cmd,
    output lrukv_pkg::lrukv_stat_t           stat,
    input  wire lrukv_pkg::lrukv_req_t       req_in,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data,
    output lrukv_pkg::lrukv_rsp_t            rsp_out
);

    import lrukv_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CW-1:0] N_CNT = CW'(MAX_ENTRIES);
    localparam logic [EW-1:0] N_EXT = EW'(MAX_ENTRIES);

    // Request and configuration.
    lrukv_req_t          req_reg;
    logic [CAP_W-1:0]    cap_reg;

    // Entry state.
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [CW-1:0]          occ_reg;

    // Sweep counter and read pipeline.
    logic [CW-1:0] cnt_reg;
    logic          pend_reg;
    logic [IW-1:0] pend_idx_reg;
    logic          issue;

    // Scan trackers.
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] hit_rank_reg;
    logic          any_reg;
    logic [IW-1:0] best_reg;
    logic [IW-1:0] oldest_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;

    // Decision results.
    logic [IW-1:0] target_reg;
    logic [IW-1:0] old_rank_reg;
    logic          age_all_reg;
    logic          promote_reg;
    logic [31:0]   get_value_reg;
    lrukv_rsp_t    rsp_reg;

    // Memory ports.
    logic [31:0]   key_rd;
    logic [31:0]   val_rd;
    logic [IW-1:0] rank_rd;
    logic          key_we;
    logic [IW-1:0] key_wa;
    logic          val_we;
    logic [IW-1:0] val_wa;
    logic          rank_we;
    logic [IW-1:0] rank_wa;
    logic [IW-1:0] rank_wd;

    // Decision terms.
    logic          is_put;
    logic [EW-1:0] cap_ext;
    logic [EW-1:0] eff_cap;
    logic          cap_full;
    logic          evict;
    logic          fill;
    logic          eval_scan;
    logic          eval_prom;
    logic          pend_valid;
    logic          age_entry;

    // Effective capacity: zero acts as one, larger than the store saturates.
    always_comb begin
        cap_ext = EW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > N_EXT) begin
            eff_cap = N_EXT;
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign is_put   = (req_reg.cmd == CMD_PUT);
    assign cap_full = (EW'(occ_reg) >= eff_cap);
    assign evict    = !hit_reg && is_put && cap_full && any_reg;
    assign fill     = !hit_reg && is_put && !evict && free_found_reg;

    // Sweep: one entry address issued per cycle, evaluated in the following cycle.
    assign issue      = cmd.sweep_run && (cnt_reg < N_CNT);
    assign eval_scan  = pend_reg && cmd.scan_mode;
    assign eval_prom  = pend_reg && !cmd.scan_mode;
    assign pend_valid = valid_reg[pend_idx_reg];
    assign age_entry  = eval_prom && pend_valid && (pend_idx_reg != target_reg)
                        && (age_all_reg || (rank_rd < old_rank_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else if (cmd.sweep_clear) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= issue;
            if (issue) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= cnt_reg[IW-1:0];
    end

    assign stat.sweep_done     = (cnt_reg == N_CNT) && !pend_reg;
    assign stat.promote_needed = promote_reg;

    // Scan trackers: first valid key match, oldest valid entry, first free slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            any_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.capture) begin
            hit_reg        <= 1'b0;
            any_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (eval_scan) begin
            if (pend_valid && (key_rd == $unsigned(req_reg.key)) && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (pend_valid && (!any_reg || (rank_rd >= best_reg))) begin
                any_reg <= 1'b1;
            end
            if (!pend_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_scan) begin
            if (pend_valid && (key_rd == $unsigned(req_reg.key)) && !hit_reg) begin
                hit_idx_reg  <= pend_idx_reg;
                hit_rank_reg <= rank_rd;
            end
            if (pend_valid && (!any_reg || (rank_rd >= best_reg))) begin
                best_reg   <= rank_rd;
                oldest_reg <= pend_idx_reg;
            end
            if (!pend_valid && !free_found_reg) begin
                free_idx_reg <= pend_idx_reg;
            end
        end
    end

    // Request capture and capacity register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Decision: valid bits, occupancy and promotion control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            occ_reg     <= '0;
            promote_reg <= 1'b0;
        end else if (cmd.decide) begin
            promote_reg <= hit_reg || evict || fill;
            if (fill) begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg                 <= occ_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            target_reg   <= hit_reg ? hit_idx_reg : (evict ? oldest_reg : free_idx_reg);
            old_rank_reg <= hit_reg ? hit_rank_reg : best_reg;
            age_all_reg  <= fill;
        end
        if (cmd.latch) begin
            get_value_reg <= val_rd;
        end
    end

    // Memory write controls.
    assign key_we  = cmd.decide && (evict || fill);
    assign key_wa  = evict ? oldest_reg : free_idx_reg;
    assign val_we  = cmd.decide && is_put && (hit_reg || evict || fill);
    assign val_wa  = hit_reg ? hit_idx_reg : key_wa;
    assign rank_we = cmd.final_wr || age_entry;
    assign rank_wa = cmd.final_wr ? target_reg : pend_idx_reg;
    assign rank_wd = cmd.final_wr ? '0 : (rank_rd + IW'(1));

    lrukv_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_wa),
        .wr_data ($unsigned(req_reg.key)),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (key_rd)
    );

    lrukv_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTRIES)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_wa),
        .wr_data ($unsigned(req_reg.value)),
        .rd_addr (hit_idx_reg),
        .rd_data (val_rd)
    );

    lrukv_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ENTRIES)
    ) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rank_wa),
        .wr_data (rank_wd),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (rank_rd)
    );

    // Response register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            rsp_reg.found <= hit_reg;
            if (is_put) begin
                rsp_reg.read_value <= '0;
            end else if (hit_reg) begin
                rsp_reg.read_value <= $signed(get_value_reg);
            end else begin
                rsp_reg.read_value <= MISS_VALUE;
            end
        end
    end

    assign rsp_out = rsp_reg;

    // Occupancy always matches the number of valid entries.
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == CW'($countones(valid_reg)))
        else $error("occupancy out of step with valid bits");

    // A new entry is only placed into a slot that was free.
    a_fill_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.decide && fill) |-> !valid_reg[free_idx_reg])
        else $error("fill into an occupied slot");

    // The sweep counter never runs past the entry count.
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= N_CNT)
        else $error("sweep counter overrun");

endmodule

`default_nettype wire
